/* rtl/pwst_pkg.sv */
// Package for the pulse-width serial transmitter.
// Phase codes, register indexes, reset values and the shared structs.
// No dependencies.
`default_nettype none

package pwst_pkg;

	// defaults for the top-level parameters
	localparam int DATA_BITS_DEF  = 8;
	localparam int TICK_WIDTH_DEF = 16;

	// field widths
	localparam int CMD_W    = 8;
	localparam int DUR_W    = 16;
	localparam int CFG_IDX_W = 3;
	localparam int OUT_W    = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SETUP     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HI  = 3'd4;

	// register reset values, in ticks
	localparam logic [DUR_W-1:0] SETUP_RST    = 16'd50;
	localparam logic [DUR_W-1:0] START_RST    = 16'd150;
	localparam logic [DUR_W-1:0] ONE_LOW_RST  = 16'd75;
	localparam logic [DUR_W-1:0] ZERO_LOW_RST = 16'd150;
	localparam logic [DUR_W-1:0] FRAME_HI_RST = 16'd75;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_SETUP = 3'd1,
		PH_START = 3'd2,
		PH_LOW   = 3'd3,
		PH_HIGH  = 3'd4
	} phase_t;

	typedef struct packed {
		logic [DUR_W-1:0] setup_ticks;
		logic [DUR_W-1:0] start_ticks;
		logic [DUR_W-1:0] one_low_ticks;
		logic [DUR_W-1:0] zero_low_ticks;
		logic [DUR_W-1:0] frame_high_ticks;
	} pwst_cfg_t;

	typedef struct packed {
		logic             rejected;
		logic [CMD_W-1:0] sent_command;
		logic             sent;
		logic             busy_res;
		logic             data_level;
		logic             ctrl_level;
	} pwst_res_t;

endpackage

`default_nettype wire

/* rtl/pwst_seq.sv */
// Sequencer for the pulse-width serial transmitter: phase, tick counter and
// bit index, advanced once per accepted request. Depends on pwst_pkg.
`default_nettype none

module pwst_seq #(
	parameter int DATA_BITS  = pwst_pkg::DATA_BITS_DEF,
	parameter int TICK_WIDTH = pwst_pkg::TICK_WIDTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire logic                       mode,
	input  wire logic [pwst_pkg::CMD_W-1:0] command,
	input  wire pwst_pkg::pwst_cfg_t        cfg,
	output pwst_pkg::pwst_res_t             res
);

	localparam int BIT_W = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
	localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;
	localparam logic [BIT_W-1:0] LAST_IDX = BIT_W'(DATA_BITS - 1);

	pwst_pkg::phase_t              phase_q, phase_d;
	logic [TICK_WIDTH-1:0]         tick_q, tick_d, tick_inc;
	logic [DATA_BITS-1:0]          shift_q, shift_d;
	logic [pwst_pkg::CMD_W-1:0]    held_q, held_d;
	logic [BIT_W-1:0]              bits_q, bits_d;
	logic                          ctrl_q, ctrl_d, data_q, data_d;
	logic [pwst_pkg::DUR_W-1:0]    dur_raw;
	logic [31:0]                   dur_c;
	logic                          sent, rejected;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pwst_pkg::PH_IDLE;
			tick_q  <= '0;
			shift_q <= '0;
			held_q  <= '0;
			bits_q  <= '0;
			ctrl_q  <= 1'b0;
			data_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			shift_q <= shift_d;
			held_q  <= held_d;
			bits_q  <= bits_d;
			ctrl_q  <= ctrl_d;
			data_q  <= data_d;
		end
	end

	// duration of the current interval, clamped to the counter range
	always_comb begin
		unique case (phase_q)
			pwst_pkg::PH_SETUP: dur_raw = cfg.setup_ticks;
			pwst_pkg::PH_START: dur_raw = cfg.start_ticks;
			pwst_pkg::PH_LOW:   dur_raw = shift_q[bits_q] ? cfg.one_low_ticks
			                                              : cfg.zero_low_ticks;
			default:            dur_raw = cfg.frame_high_ticks;
		endcase
		dur_c = (32'(dur_raw) > 32'(TICK_MAX)) ? 32'(TICK_MAX) : 32'(dur_raw);
	end

	assign tick_inc = (tick_q == TICK_MAX) ? tick_q : tick_q + 1'b1;

	always_comb begin
		phase_d  = phase_q;
		tick_d   = tick_q;
		shift_d  = shift_q;
		held_d   = held_q;
		bits_d   = bits_q;
		ctrl_d   = ctrl_q;
		data_d   = data_q;
		sent     = 1'b0;
		rejected = 1'b0;
		if (mode) begin
			if (phase_q == pwst_pkg::PH_IDLE) begin
				held_d  = command;
				shift_d = DATA_BITS'(command);
				bits_d  = '0;
				tick_d  = '0;
				phase_d = pwst_pkg::PH_SETUP;
				ctrl_d  = 1'b1;
				data_d  = 1'b0;
			end else begin
				rejected = 1'b1;
			end
		end else if (phase_q != pwst_pkg::PH_IDLE) begin
			tick_d = tick_inc;
			if (32'(tick_inc) >= dur_c) begin
				tick_d = '0;
				unique case (phase_q)
					pwst_pkg::PH_SETUP: begin
						phase_d = pwst_pkg::PH_START;
						data_d  = 1'b1;
					end
					pwst_pkg::PH_START: begin
						phase_d = pwst_pkg::PH_LOW;
						data_d  = 1'b0;
						bits_d  = LAST_IDX;
					end
					pwst_pkg::PH_LOW: begin
						phase_d = pwst_pkg::PH_HIGH;
						data_d  = 1'b1;
					end
					default: begin
						if (bits_q == '0) begin
							phase_d = pwst_pkg::PH_IDLE;
							ctrl_d  = 1'b0;
							data_d  = 1'b0;
							sent    = 1'b1;
						end else begin
							bits_d  = bits_q - 1'b1;
							phase_d = pwst_pkg::PH_LOW;
							data_d  = 1'b0;
						end
					end
				endcase
			end
		end
	end

	always_comb begin
		res.ctrl_level   = ctrl_d;
		res.data_level   = data_d;
		res.busy_res     = (phase_d != pwst_pkg::PH_IDLE);
		res.sent         = sent;
		res.sent_command = sent ? held_q : '0;
		res.rejected     = rejected;
	end

	// control line is high exactly while a word is in flight
	a_ctrl_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_q == (phase_q != pwst_pkg::PH_IDLE))
		else $error("control line disagrees with phase");

	// completion always leaves the sequencer idle
	a_sent_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && sent |=> phase_q == pwst_pkg::PH_IDLE)
		else $error("sent without returning to idle");

	// a start while idle always enters setup with a cleared counter
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		step && mode && phase_q == pwst_pkg::PH_IDLE
		|=> phase_q == pwst_pkg::PH_SETUP && tick_q == '0)
		else $error("start not taken");

	// no request, no movement
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(phase_q) && $stable(tick_q) && $stable(bits_q))
		else $error("state moved without a request");

endmodule

`default_nettype wire

/* rtl/pulse_width_serial_transmitter.sv */
// Top level of the pulse-width serial transmitter: configuration registers,
// sequencer and the result register. Depends on pwst_pkg and pwst_seq.
`default_nettype none

// Channel   Direction  Handshake         Payload
// s_*       in         s_tvalid/s_tready tdata: command; tuser: mode
// m_*       out        m_tvalid/m_tready tdata: line levels, status, sent word
// cfg_*     in         cfg_we            cfg_index selects, cfg_data value
//
// One request in, one result out: the sequencer updates its phase and tick
// counter in the cycle a request is taken, and the result sits in m_tdata
// from the next cycle. Throughput is one request per cycle while the result
// register is drained; s_tready drops only while a result waits and m_tready
// is low. Reset clears the sequencer, the result valid flag and loads the
// register defaults. Configuration writes take effect once registered.

module pulse_width_serial_transmitter #(
	parameter int DATA_BITS  = pwst_pkg::DATA_BITS_DEF,
	parameter int TICK_WIDTH = pwst_pkg::TICK_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input stream
	input  wire logic                           s_tvalid,
	output      logic                           s_tready,
	input  wire logic [pwst_pkg::CMD_W-1:0]     s_tdata,  // [7:0] command
	input  wire logic                           s_tuser,  // [0] mode
	// result stream
	output      logic                           m_tvalid,
	input  wire logic                           m_tready,
	// [0] ctrl_level, [1] data_level, [2] busy_res, [3] sent,
	// [11:4] sent_command, [12] rejected, [15:13] zero
	output      logic [pwst_pkg::OUT_W-1:0]     m_tdata,
	// configuration
	input  wire logic                           cfg_we,
	input  wire logic [pwst_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [pwst_pkg::DUR_W-1:0]     cfg_data
);

	localparam int RES_W = $bits(pwst_pkg::pwst_res_t);

	pwst_pkg::pwst_cfg_t cfg_q;
	pwst_pkg::pwst_res_t res;
	logic                accept;
	logic                m_tvalid_q;
	logic [pwst_pkg::OUT_W-1:0] m_tdata_q;

	// duration registers; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setup_ticks      <= pwst_pkg::SETUP_RST;
			cfg_q.start_ticks      <= pwst_pkg::START_RST;
			cfg_q.one_low_ticks    <= pwst_pkg::ONE_LOW_RST;
			cfg_q.zero_low_ticks   <= pwst_pkg::ZERO_LOW_RST;
			cfg_q.frame_high_ticks <= pwst_pkg::FRAME_HI_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pwst_pkg::REG_SETUP:    cfg_q.setup_ticks      <= cfg_data;
				pwst_pkg::REG_START:    cfg_q.start_ticks      <= cfg_data;
				pwst_pkg::REG_ONE_LOW:  cfg_q.one_low_ticks    <= cfg_data;
				pwst_pkg::REG_ZERO_LOW: cfg_q.zero_low_ticks   <= cfg_data;
				pwst_pkg::REG_FRAME_HI: cfg_q.frame_high_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	// take a request whenever the result slot is free or being emptied
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	pwst_seq #(
		.DATA_BITS  (DATA_BITS),
		.TICK_WIDTH (TICK_WIDTH)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (accept),
		.mode    (s_tuser),
		.command (s_tdata),
		.cfg     (cfg_q),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= pwst_pkg::OUT_W'(RES_W'(res));
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

/* bench/pwst_checker.sv */
// Scoreboard for pulse_width_serial_transmitter: tracks line levels per request
// and compares every result against the predicted line status.
// Depends on pwst_pkg.
`timescale 1ns / 100ps

module pwst_checker
	import pwst_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [CMD_W-1:0]     s_tdata,   // [7:0] command
	input  logic                 s_tuser,   // [0] mode
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [OUT_W-1:0]     m_tdata,   // [0] ctrl, [1] data, [2] busy, [3] sent,
	                                        // [11:4] sent_command, [12] rejected
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DUR_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   owed_count
);

	localparam int WORD_BITS = DATA_BITS_DEF;

	// shadow timing registers
	pwst_cfg_t timing;

	// transmitter shadow state
	phase_t           ph;
	logic [DUR_W-1:0] ticks_spent;
	logic [CMD_W-1:0] shift_word;
	logic [CMD_W-1:0] held_word;
	logic [3:0]       bit_idx;
	logic             ctrl_lvl;
	logic             data_lvl;

	pwst_res_t line_status_due[$];
	pwst_res_t want;
	pwst_res_t got;
	logic [DUR_W-1:0] interval;
	int fails;

	task automatic check_field(input string name, input int unsigned w, input int unsigned g);
		if (w != g) begin
			$error("%s: expected %0h, got %0h", name, w, g);
			fails++;
		end
	endtask

	// length of the interval the transmitter is in now; zero behaves as one tick
	function automatic logic [DUR_W-1:0] interval_len();
		logic [DUR_W-1:0] d;
		case (ph)
			PH_SETUP: d = timing.setup_ticks;
			PH_START: d = timing.start_ticks;
			PH_LOW:   d = shift_word[bit_idx] ? timing.one_low_ticks : timing.zero_low_ticks;
			default:  d = timing.frame_high_ticks;
		endcase
		return d;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing.setup_ticks      = SETUP_RST;
			timing.start_ticks      = START_RST;
			timing.one_low_ticks    = ONE_LOW_RST;
			timing.zero_low_ticks   = ZERO_LOW_RST;
			timing.frame_high_ticks = FRAME_HI_RST;
			ph          = PH_IDLE;
			ticks_spent = '0;
			shift_word  = '0;
			held_word   = '0;
			bit_idx     = '0;
			ctrl_lvl    = 1'b0;
			data_lvl    = 1'b0;
			line_status_due.delete();
			fails = 0;
			fail_count <= 0;
			owed_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SETUP:    timing.setup_ticks      = cfg_data;
					REG_START:    timing.start_ticks      = cfg_data;
					REG_ONE_LOW:  timing.one_low_ticks    = cfg_data;
					REG_ZERO_LOW: timing.zero_low_ticks   = cfg_data;
					REG_FRAME_HI: timing.frame_high_ticks = cfg_data;
					default: ;
				endcase
			end

			// compare first: a result taken now belongs to an earlier request
			if (m_tvalid && m_tready) begin
				got = pwst_res_t'(m_tdata[12:0]);
				if (line_status_due.size() == 0) begin
					$error("result with no request waiting: %0h", m_tdata);
					fails++;
				end else begin
					want = line_status_due.pop_front();
					check_field("ctrl_level", want.ctrl_level, got.ctrl_level);
					check_field("data_level", want.data_level, got.data_level);
					check_field("busy_res", want.busy_res, got.busy_res);
					check_field("sent", want.sent, got.sent);
					check_field("sent_command", want.sent_command, got.sent_command);
					check_field("rejected", want.rejected, got.rejected);
					check_field("pad", 0, m_tdata[OUT_W-1:13]);
				end
			end

			if (s_tvalid && s_tready) begin
				want = '0;
				if (s_tuser) begin
					// start request
					if (ph == PH_IDLE) begin
						held_word   = s_tdata;
						shift_word  = s_tdata;
						bit_idx     = '0;
						ticks_spent = '0;
						ph          = PH_SETUP;
						ctrl_lvl    = 1'b1;
						data_lvl    = 1'b0;
					end else begin
						want.rejected = 1'b1;
					end
				end else if (ph != PH_IDLE) begin
					if (ticks_spent != '1)
						ticks_spent++;
					interval = interval_len();
					if (ticks_spent >= interval) begin
						ticks_spent = '0;
						case (ph)
							PH_SETUP: begin
								ph = PH_START;
								data_lvl = 1'b1;
							end
							PH_START: begin
								ph = PH_LOW;
								data_lvl = 1'b0;
								bit_idx = 4'(WORD_BITS - 1);
							end
							PH_LOW: begin
								ph = PH_HIGH;
								data_lvl = 1'b1;
							end
							default: begin
								if (bit_idx == 0) begin
									ph = PH_IDLE;
									ctrl_lvl = 1'b0;
									data_lvl = 1'b0;
									want.sent = 1'b1;
									want.sent_command = held_word;
								end else begin
									bit_idx--;
									ph = PH_LOW;
									data_lvl = 1'b0;
								end
							end
						endcase
					end
				end
				want.ctrl_level = ctrl_lvl;
				want.data_level = data_lvl;
				want.busy_res   = (ph != PH_IDLE);
				line_status_due.push_back(want);
			end

			fail_count <= fails;
			owed_count <= line_status_due.size();
		end
	end

endmodule

/* bench/tb.sv */
// Top of the bench for pulse_width_serial_transmitter: clock, reset, request
// and result traffic, timing register writes and the verdict.
// Depends on pwst_pkg, the transmitter RTL and pwst_checker.
`timescale 1ns / 100ps

module tb;
	import pwst_pkg::*;

	// request kinds carried in tuser
	localparam logic MODE_TICK  = 1'b0;
	localparam logic MODE_START = 1'b1;

	// cycles without any accepted request or result before we give up
	localparam int QUIET_LIMIT = 2000;
	// length of the deliberate receiver hold-off
	localparam int HOLD_CYCLES = 64;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [CMD_W-1:0]     s_tdata = '0;   // [7:0] command
	logic                 s_tuser = 1'b0; // [0] mode
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_W-1:0]     m_tdata;        // [0] ctrl, [1] data, [2] busy, [3] sent,
	                                      // [11:4] sent_command, [12] rejected
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DUR_W-1:0]     cfg_data = '0;

	int fail_count;
	int owed_count;

	// idling knobs, in percent of cycles
	int send_gap_pct = 9;
	int recv_gap_pct = 56;

	// receiver hold-off handshake between the stimulus and receiver processes
	int stall_asked = 0;
	int stall_taken = 0;
	int hold_left = 0;

	int req_count = 0;
	int quiet = 0;

	// bench copy of the timing registers, used only to size each word's ticks
	pwst_cfg_t timing;

	pulse_width_serial_transmitter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pwst_checker scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.owed_count (owed_count)
	);

	always #5 clk = ~clk;

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Receiver: random back-pressure, plus a long hold-off whenever the
	// stimulus asks for one. The hold is counted here, not by the sender.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (stall_asked != stall_taken) begin
			stall_taken <= stall_asked;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// Watchdog: any accepted request or result counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	// One request, with a random gap ahead of it. tvalid stays high across
	// back-to-back requests; it is only lowered in a cycle that idles.
	task automatic push_request(input logic mode, input logic [CMD_W-1:0] cmd);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= cmd;
		do
			@(posedge clk);
		while (!s_tready);
		req_count++;
	endtask

	// Sender pause: nothing offered until every result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (owed_count != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// Writes all five timing registers back to back, after a drain; a word may still be in flight
	task automatic set_timing(input logic [DUR_W-1:0] su, st, one, zero, fr);
		timing.setup_ticks      = su;
		timing.start_ticks      = st;
		timing.one_low_ticks    = one;
		timing.zero_low_ticks   = zero;
		timing.frame_high_ticks = fr;
		cfg_we <= 1'b1;
		cfg_index <= REG_SETUP;
		cfg_data  <= su;
		@(posedge clk);
		cfg_index <= REG_START;
		cfg_data  <= st;
		@(posedge clk);
		cfg_index <= REG_ONE_LOW;
		cfg_data  <= one;
		@(posedge clk);
		cfg_index <= REG_ZERO_LOW;
		cfg_data  <= zero;
		@(posedge clk);
		cfg_index <= REG_FRAME_HI;
		cfg_data  <= fr;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly short intervals, zero now and then
	task automatic set_short_timing();
		set_timing(16'($urandom_range(4)), 16'($urandom_range(4)), 16'($urandom_range(4)),
		           16'($urandom_range(4)), 16'($urandom_range(4)));
	endtask

	// zero-length intervals still take one tick
	function automatic int ticks_of(input logic [DUR_W-1:0] d);
		return (d == 0) ? 1 : int'(d);
	endfunction

	// ticks needed from a start request until the word is sent
	function automatic int word_ticks(input logic [CMD_W-1:0] cmd);
		int total;
		total = ticks_of(timing.setup_ticks) + ticks_of(timing.start_ticks);
		for (int b = 0; b < DATA_BITS_DEF; b++)
			total += ticks_of(cmd[b] ? timing.one_low_ticks : timing.zero_low_ticks)
			         + ticks_of(timing.frame_high_ticks);
		return total;
	endfunction

	// A whole word: start request, exactly enough ticks to finish it, with
	// stray start requests while busy (these must be rejected), then a few
	// ticks while idle. Tick commands are random since the block ignores them.
	task automatic send_word(input logic [CMD_W-1:0] cmd, input int stray_pct);
		int n;
		n = word_ticks(cmd);
		push_request(MODE_START, cmd);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < stray_pct)
				push_request(MODE_START, CMD_W'($urandom_range(255)));
			push_request(MODE_TICK, CMD_W'($urandom_range(255)));
		end
		repeat ($urandom_range(2))
			push_request(MODE_TICK, CMD_W'($urandom_range(255)));
	endtask

	task automatic random_words(input int n);
		int stop;
		stop = req_count + n;
		while (req_count < stop)
			send_word(CMD_W'($urandom_range(255)), 6);
	endtask

	task automatic random_phase(input int n);
		drain();
		set_short_timing();
		random_words(n);
	endtask

	initial begin
		timing.setup_ticks      = SETUP_RST;
		timing.start_ticks      = START_RST;
		timing.one_low_ticks    = ONE_LOW_RST;
		timing.zero_low_ticks   = ZERO_LOW_RST;
		timing.frame_high_ticks = FRAME_HI_RST;
		while (!arst_n)
			@(posedge clk);
		@(posedge clk);

		// reset timing: ticks while idle do nothing, then a word is started
		// and run past the end of the setup interval (50 ticks) into its start bit
		push_request(MODE_TICK, 8'hFF);
		push_request(MODE_TICK, 8'h00);
		push_request(MODE_START, 8'hA5);
		for (int i = 0; i < 55; i++)
			push_request(MODE_TICK, CMD_W'($urandom_range(255)));

		// zero-length intervals: each ends on its first tick; 17 ticks first
		// finish the word left in its start bit above
		drain();
		set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		for (int i = 0; i < 17; i++)
			push_request(MODE_TICK, CMD_W'($urandom_range(255)));
		send_word(8'hFF, 0);
		send_word(8'h00, 0);
		send_word(8'h80, 50);
		send_word(8'h01, 0);

		drain();
		set_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
		send_word(8'h5A, 20);

		random_phase(40);
		random_phase(40);

		// sender idles more than the receiver now
		send_gap_pct <= 56;
		recv_gap_pct <= 9;
		drain();
		set_short_timing();
		random_words(30);
		// receiver holds off while requests keep coming, so the block backs up
		stall_asked <= stall_asked + 1;
		random_words(30);
		// sender waits for every result before carrying on
		drain();
		random_words(30);
		random_phase(40);

		// no idling: longer intervals, one and zero bits of unequal length,
		// and an unused register holding a value near the top of its range
		send_gap_pct <= 0;
		recv_gap_pct <= 0;
		drain();
		set_timing(16'd20, 16'd1, 16'hFFFF, 16'd6, 16'd2);
		send_word(8'h00, 0);
		drain();
		set_timing(16'd1, 16'd0, 16'd3, 16'h8000, 16'd1);
		send_word(8'hFF, 0);

		random_phase(40);
		random_phase(40);

		drain();
		repeat (5) @(posedge clk);
		if (fail_count == 0 && owed_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
